### rtl/sn_pkg.sv
// Shared constants, types and preset tables of the sensor normalizer.
`default_nettype none
package sn_pkg;

   localparam int CHANNELS     = 5;
   localparam int GAIN_CH      = 4;
   localparam int READING_BITS = 8;
   localparam int SUM_W        = 16;
   localparam int CNT_W        = 8;
   localparam int AVG_W        = 8;
   localparam int LVL_W        = 23;
   localparam int DVD_W        = 29;
   localparam int DVS_W        = 23;
   localparam int STEP_W       = 5;

   localparam logic [CNT_W-1:0] MAX_SAMPLES   = 8'd255;
   localparam logic [DVD_W-1:0] GAIN_NUM      = 29'd5242880;
   localparam logic [DVD_W-1:0] RECIP_NUM     = 29'd268435456;
   localparam logic [23:0]      LEVEL_MAX     = 24'd5222400;
   localparam logic [23:0]      RECIP_MAX     = 24'd16777215;
   localparam logic [LVL_W-1:0] RECIP_MIN_LVL = 23'd16;

   typedef enum logic [2:0] {
      FUNC_SAMPLE = 3'd0,
      FUNC_UPDATE = 3'd1,
      FUNC_CALIB  = 3'd2,
      FUNC_CLEAR  = 3'd3,
      FUNC_PRESET = 3'd4
   } func_type;

   localparam logic CSR_PRESET_SELECT = 1'b0;
   localparam logic CSR_MIDDLE_GAIN   = 1'b1;

   // Bounds of the two stored tables for channel c; sel 1 or 2.
   function automatic logic [AVG_W-1:0] preset_floor(input logic [1:0] sel,
                                                     input logic [1:0] c);
      logic [AVG_W-1:0] v;
      v = 8'd9;
      case (c)
         2'd0: v = 8'd9;
         2'd1: v = 8'd8;
         2'd2: v = (sel == 2'd1) ? 8'd11 : 8'd9;
         2'd3: v = (sel == 2'd1) ? 8'd9 : 8'd10;
         default: v = 8'd9;
      endcase
      return v;
   endfunction

   function automatic logic [AVG_W-1:0] preset_ceiling(input logic [1:0] sel,
                                                       input logic [1:0] c);
      logic [AVG_W-1:0] v;
      v = 8'd71;
      case (c)
         2'd0: v = (sel == 2'd1) ? 8'd71 : 8'd68;
         2'd1: v = (sel == 2'd1) ? 8'd71 : 8'd73;
         2'd2: v = (sel == 2'd1) ? 8'd69 : 8'd70;
         2'd3: v = (sel == 2'd1) ? 8'd68 : 8'd71;
         default: v = 8'd71;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### rtl/sn_div.sv
// Per-lane restoring divider, one quotient bit per cycle.
`default_nettype none
module sn_div
   import sn_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic [DVD_W-1:0]      quotient
);
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;
   logic [DVD_W-1:0]  dq_ff, dq_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W+1:0]  trial;

   always_comb begin
      trial   = {1'b0, rem_ff, dq_ff[DVD_W-1]} - {2'b00, dvs_ff};
      step_in = step_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = (step_ff == STEP_W'(1));
      if (start) begin
         step_in = STEP_W'(DVD_W);
         dq_in   = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (step_ff != '0) begin
         step_in = step_ff - STEP_W'(1);
         if (!trial[DVS_W+1]) begin
            rem_in = trial[DVS_W-1:0];
            dq_in  = {dq_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DVS_W-2:0], dq_ff[DVD_W-1]};
            dq_in  = {dq_ff[DVD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;
endmodule
`default_nettype wire

### rtl/five_channel_sensor_normalizer.sv
// Top level: five-lane sensor accumulator, normalizer and error merge.
// A sample, clear or ignored request does not stall the block; the next request is taken at once.
// An update makes two passes of the 29-step lane dividers (average, then reciprocal),
// with launch, multiply and output-load states around them; its result is registered
// in the output stage, and a stalled result holds the block.
// Calibrate and preset make one divider pass for the gains.
// Synchronous active-high reset clears sums, count, bounds (floor 255), gains and levels.
`default_nettype none
module five_channel_sensor_normalizer
   import sn_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_func,
   input  wire logic [7:0]        req_reading_x_left,
   input  wire logic [7:0]        req_reading_x_right,
   input  wire logic [7:0]        req_reading_y_left,
   input  wire logic [7:0]        req_reading_y_right,
   input  wire logic [7:0]        req_reading_middle,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [LVL_W-1:0]       rsp_level_x_left,
   output logic [LVL_W-1:0]       rsp_level_x_right,
   output logic [LVL_W-1:0]       rsp_level_y_left,
   output logic [LVL_W-1:0]       rsp_level_y_right,
   output logic [LVL_W-1:0]       rsp_level_middle,
   output logic signed [24:0]     rsp_lateral_error,
   output logic signed [23:0]     rsp_vertical_error,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_index,
   input  wire logic [22:0]       csr_data
);
   // The sequencer walks through one-hot states; each GO state launches all lane
   // dividers with operands chosen for that phase, and the RUN state waits for them.
   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_AVG_GO    = 9'b000000010,
      ST_AVG_RUN   = 9'b000000100,
      ST_NORM      = 9'b000001000,
      ST_RECIP_GO  = 9'b000010000,
      ST_RECIP_RUN = 9'b000100000,
      ST_EMIT      = 9'b001000000,
      ST_GAIN_GO   = 9'b010000000,
      ST_GAIN_RUN  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]       preset_ff;
   logic [LVL_W-1:0] mid_gain_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [SUM_W-1:0] sum_ff   [CHANNELS];
   logic [AVG_W-1:0] avg_ff   [CHANNELS];
   logic [AVG_W-1:0] floor_ff [CHANNELS];
   logic [AVG_W-1:0] ceil_ff  [CHANNELS];
   logic [LVL_W-1:0] lvl_ff   [CHANNELS];
   logic [LVL_W-1:0] gain_ff  [GAIN_CH];

   logic [7:0]       reading  [CHANNELS];
   logic [DVD_W-1:0] dvd      [CHANNELS];
   logic [DVS_W-1:0] dvs      [CHANNELS];
   logic [DVD_W-1:0] quo      [CHANNELS];
   logic [CHANNELS-1:0] lane_done;
   logic [LVL_W-1:0] gain_sel [CHANNELS];
   logic [AVG_W-1:0] avg_q    [CHANNELS];
   logic [LVL_W-1:0] lvl_new  [CHANNELS];
   logic [23:0]      recip    [2];

   logic             accept, div_start, out_load, do_sample;
   logic             rsp_valid_ff;
   logic [LVL_W-1:0] out_lvl_ff [CHANNELS];
   logic [24:0]      lat_ff;
   logic [23:0]      vert_ff;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign div_start = (state_ff == ST_AVG_GO) || (state_ff == ST_RECIP_GO)
                      || (state_ff == ST_GAIN_GO);
   assign out_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign do_sample = accept && (req_func == FUNC_SAMPLE) && (cnt_ff < MAX_SAMPLES);

   assign reading[0] = req_reading_x_left;
   assign reading[1] = req_reading_x_right;
   assign reading[2] = req_reading_y_left;
   assign reading[3] = req_reading_y_right;
   assign reading[4] = req_reading_middle;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_UPDATE: state_in = ST_AVG_GO;
                  FUNC_CALIB:  state_in = ST_GAIN_GO;
                  FUNC_PRESET: state_in = ST_GAIN_GO;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_AVG_GO:    state_in = ST_AVG_RUN;
         ST_AVG_RUN:   state_in = lane_done[0] ? ST_NORM : ST_AVG_RUN;
         ST_NORM:      state_in = ST_RECIP_GO;
         ST_RECIP_GO:  state_in = ST_RECIP_RUN;
         ST_RECIP_RUN: state_in = lane_done[0] ? ST_EMIT : ST_RECIP_RUN;
         ST_EMIT:      state_in = out_load ? ST_IDLE : ST_EMIT;
         ST_GAIN_GO:   state_in = ST_GAIN_RUN;
         ST_GAIN_RUN:  state_in = lane_done[0] ? ST_IDLE : ST_GAIN_RUN;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Five parallel lanes: each owns its channel's sum, bounds and level, and one divider.
   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      logic [AVG_W-1:0] range;
      logic [AVG_W-1:0] diff;
      logic [30:0]      prod;
      logic [31:0]      rnd;

      if (c < GAIN_CH) begin : g_tab
         assign gain_sel[c] = gain_ff[c];
         always_ff @(posedge clock) begin
            if (reset) begin
               gain_ff[c] <= '0;
            end else if ((state_ff == ST_GAIN_RUN) && lane_done[0]) begin
               gain_ff[c] <= quo[c][LVL_W-1:0];
            end
         end
      end else begin : g_mid
         assign gain_sel[c] = mid_gain_ff;
      end

      always_comb begin
         range = (ceil_ff[c] > floor_ff[c]) ? (ceil_ff[c] - floor_ff[c]) : AVG_W'(1);
         dvd[c] = '0;
         dvs[c] = DVS_W'(1);
         case (state_ff)
            ST_AVG_GO: begin
               dvd[c] = DVD_W'(sum_ff[c]);
               dvs[c] = DVS_W'(cnt_ff);
            end
            ST_RECIP_GO: begin
               if (c < 2) begin
                  dvd[c] = RECIP_NUM + DVD_W'(lvl_ff[c] >> 1);
                  dvs[c] = lvl_ff[c];
               end
            end
            ST_GAIN_GO: begin
               dvd[c] = GAIN_NUM + DVD_W'(range >> 1);
               dvs[c] = DVS_W'(range);
            end
            default: begin
               dvd[c] = '0;
               dvs[c] = DVS_W'(1);
            end
         endcase
         avg_q[c]   = (quo[c][DVD_W-1:AVG_W] != '0) ? 8'd255 : quo[c][AVG_W-1:0];
         diff       = avg_q[c] - floor_ff[c];
         prod       = gain_sel[c] * diff;
         rnd        = {1'b0, prod} + 32'd128;
         lvl_new[c] = (rnd[31:8] > LEVEL_MAX) ? LEVEL_MAX[LVL_W-1:0] : rnd[30:8];
      end

      sn_div u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start),
         .dividend (dvd[c]),
         .divisor  (dvs[c]),
         .done     (lane_done[c]),
         .quotient (quo[c])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            sum_ff[c]   <= '0;
            avg_ff[c]   <= '0;
            floor_ff[c] <= 8'd255;
            ceil_ff[c]  <= '0;
            lvl_ff[c]   <= '0;
         end else begin
            if (do_sample) begin
               sum_ff[c] <= sum_ff[c] + SUM_W'(reading[c][READING_BITS-1:0]);
            end
            if (state_ff == ST_NORM) begin
               sum_ff[c] <= '0;
               if (cnt_ff != '0) begin
                  avg_ff[c] <= avg_q[c];
                  if (avg_q[c] > floor_ff[c]) begin
                     lvl_ff[c] <= lvl_new[c];
                  end
               end
            end
            if (accept && (req_func == FUNC_CALIB)) begin
               if (avg_ff[c] < floor_ff[c]) floor_ff[c] <= avg_ff[c];
               if (avg_ff[c] > ceil_ff[c])  ceil_ff[c]  <= avg_ff[c];
            end
            // Clear and preset reach only the four table channels.
            if (c < GAIN_CH) begin
               if (accept && (req_func == FUNC_CLEAR)) begin
                  floor_ff[c] <= 8'd255;
                  ceil_ff[c]  <= '0;
               end
               if (accept && (req_func == FUNC_PRESET)
                   && ((preset_ff == 2'd1) || (preset_ff == 2'd2))) begin
                  floor_ff[c] <= preset_floor(preset_ff, 2'(c));
                  ceil_ff[c]  <= preset_ceiling(preset_ff, 2'(c));
               end
            end
         end
      end
   end

   // Merge stage: saturated reciprocals of the horizontal pair and the vertical difference.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         if (lvl_ff[i] < RECIP_MIN_LVL) begin
            recip[i] = RECIP_MAX;
         end else if (quo[i] > DVD_W'(RECIP_MAX)) begin
            recip[i] = RECIP_MAX;
         end else begin
            recip[i] = quo[i][23:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         preset_ff    <= 2'd1;
         mid_gain_ff  <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PRESET_SELECT: preset_ff   <= csr_data[1:0];
               CSR_MIDDLE_GAIN:   mid_gain_ff <= csr_data;
               default:           preset_ff   <= preset_ff;
            endcase
         end
         if (do_sample) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (state_ff == ST_NORM) begin
            cnt_ff <= '0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (out_load) begin
         for (int i = 0; i < CHANNELS; i++) begin
            out_lvl_ff[i] <= lvl_ff[i];
         end
         lat_ff  <= {1'b0, recip[0]} - {1'b0, recip[1]};
         vert_ff <= {1'b0, lvl_ff[3]} - {1'b0, lvl_ff[2]};
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_level_x_left   = out_lvl_ff[0];
   assign rsp_level_x_right  = out_lvl_ff[1];
   assign rsp_level_y_left   = out_lvl_ff[2];
   assign rsp_level_y_right  = out_lvl_ff[3];
   assign rsp_level_middle   = out_lvl_ff[4];
   assign rsp_lateral_error  = signed'(lat_ff);
   assign rsp_vertical_error = signed'(vert_ff);

   // The sample counter never passes its limit.
   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_SAMPLES) else $error("sample count beyond limit");

   // Divider completion is only seen while the sequencer waits for it.
   a_done_run: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] |-> ((state_ff == ST_AVG_RUN) || (state_ff == ST_RECIP_RUN)
                        || (state_ff == ST_GAIN_RUN)))
      else $error("divider finished outside a run state");

   // Loading the output register always presents a result in the next cycle.
   a_emit: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid) else $error("emitted result not presented");

   // An accepted update always reaches the averaging launch.
   a_upd: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == FUNC_UPDATE)) |=> (state_ff == ST_AVG_GO))
      else $error("update not started");
endmodule
`default_nettype wire

### sim/five_channel_sensor_normalizer_tb.sv
// Self-checking testbench of the five-channel sensor normalizer with its own scoreboard.
`default_nettype none
module five_channel_sensor_normalizer_tb
   import sn_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Codes 5 to 7 are not operations; the block must drop them silently.
   localparam logic [2:0] FUNC_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] FUNC_LAST_UNUSED  = 3'd7;
   localparam int RANGE_HALF_SCALE = 5242880;   // 80.0 in Q7.16
   localparam int CYCLE_LIMIT      = 1000000;
   localparam int SETTLE_CYCLES    = 80;        // longest request without a response
   localparam int LONG_HOLD        = 600;

   typedef struct packed {
      logic [4:0][22:0] levels;
      logic [24:0]      lateral;
      logic [23:0]      vertical;
   } level_report_type;

   // Scoreboard: keeps its own copy of the accumulator state, predicts the level
   // report of each update request, and compares the reports coming out.
   class normalizer_scoreboard;
      int unsigned      sums[5];
      int unsigned      count;
      int unsigned      averages[5];
      int unsigned      floors[5];
      int unsigned      ceilings[5];
      int unsigned      gains[4];
      int unsigned      levels[5];
      int unsigned      table_select;
      int unsigned      mid_gain;
      level_report_type pending_reports[$];
      int               errors;

      function new();
         table_select = 1;
         mid_gain     = 0;
         count        = 0;
         errors       = 0;
         for (int c = 0; c < 5; c++) begin
            sums[c] = 0; averages[c] = 0; floors[c] = 255; ceilings[c] = 0; levels[c] = 0;
         end
         for (int c = 0; c < 4; c++) gains[c] = 0;
      endfunction

      function void configure(logic idx, logic [22:0] data);
         if (idx == CSR_PRESET_SELECT) table_select = data[1:0];
         else mid_gain = data;
      endfunction

      function void refresh_gains();
         int unsigned span;
         for (int c = 0; c < 4; c++) begin
            span = (ceilings[c] > floors[c]) ? ceilings[c] - floors[c] : 1;
            gains[c] = ((RANGE_HALF_SCALE + span / 2) / span) & 32'h7FFFFF;
         end
      endfunction

      function int unsigned inverse_level(int unsigned v);
         longint unsigned r;
         if (v < 16) return 16777215;
         r = (64'd268435456 + v / 2) / v;
         return (r > 16777215) ? 16777215 : int'(r);
      endfunction

      function void note_request(logic [2:0] f, logic [4:0][7:0] rd);
         longint unsigned  prod;
         int unsigned      avg, g;
         level_report_type rep;
         case (f)
            FUNC_SAMPLE: if (count < 255) begin
               for (int c = 0; c < 5; c++) sums[c] = (sums[c] + rd[c]) & 32'hFFFF;
               count++;
            end
            FUNC_UPDATE: begin
               for (int c = 0; c < 5; c++) begin
                  if (count != 0) begin
                     avg = sums[c] / count;
                     if (avg > 255) avg = 255;
                     averages[c] = avg;
                     if (avg > floors[c]) begin
                        g = (c < 4) ? gains[c] : mid_gain;
                        prod = (longint'(g) * (avg - floors[c]) + 128) >> 8;
                        levels[c] = (prod > 5222400) ? 5222400 : int'(prod);
                     end
                  end
                  sums[c] = 0;
               end
               count = 0;
               for (int c = 0; c < 5; c++) rep.levels[c] = 23'(levels[c]);
               rep.lateral  = 25'(inverse_level(levels[0]) - inverse_level(levels[1]));
               rep.vertical = 24'(levels[3] - levels[2]);
               pending_reports.push_back(rep);
            end
            FUNC_CALIB: begin
               for (int c = 0; c < 5; c++) begin
                  if (averages[c] < floors[c]) floors[c] = averages[c];
                  if (averages[c] > ceilings[c]) ceilings[c] = averages[c];
               end
               refresh_gains();
            end
            FUNC_CLEAR: for (int c = 0; c < 4; c++) begin
               floors[c] = 255; ceilings[c] = 0;
            end
            FUNC_PRESET: begin
               // Table one and table two; any other selection keeps the bounds.
               if (table_select == 1) begin
                  floors   = '{9, 8, 11, 9, floors[4]};
                  ceilings = '{71, 71, 69, 68, ceilings[4]};
               end else if (table_select == 2) begin
                  floors   = '{9, 8, 9, 10, floors[4]};
                  ceilings = '{68, 73, 70, 71, ceilings[4]};
               end
               refresh_gains();
            end
            default: ;
         endcase
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_result(level_report_type got);
         level_report_type want;
         if (pending_reports.size() == 0) begin
            report("level report arrived with none outstanding");
            return;
         end
         want = pending_reports.pop_front();
         for (int c = 0; c < 5; c++)
            if (got.levels[c] !== want.levels[c])
               report($sformatf("level %0d got %0d want %0d", c, got.levels[c], want.levels[c]));
         if (got.lateral !== want.lateral)
            report($sformatf("lateral_error got %h want %h", got.lateral, want.lateral));
         if (got.vertical !== want.vertical)
            report($sformatf("vertical_error got %h want %h", got.vertical, want.vertical));
      endtask

      function int outstanding();
         return pending_reports.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_func = FUNC_SAMPLE;
   logic [4:0][7:0] req_readings = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [22:0] rsp_level_x_left, rsp_level_x_right, rsp_level_y_left;
   logic [22:0] rsp_level_y_right, rsp_level_middle;
   logic signed [24:0] rsp_lateral_error;
   logic signed [23:0] rsp_vertical_error;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = CSR_PRESET_SELECT;
   logic [22:0] csr_data = '0;

   normalizer_scoreboard levels_sb = new();

   // Knobs shared by the sender, the receiver and the phase sequencer.
   bit sender_idling   = 1'b0;
   bit receiver_idling = 1'b0;
   bit hold_request    = 1'b0;
   int hold_left       = 0;
   int stall_burst     = 0;
   int unsigned cycles = 0;
   int requests_sent   = 0;

   five_channel_sensor_normalizer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_reading_x_left  (req_readings[0]),
      .req_reading_x_right (req_readings[1]),
      .req_reading_y_left  (req_readings[2]),
      .req_reading_y_right (req_readings[3]),
      .req_reading_middle  (req_readings[4]),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_level_x_left    (rsp_level_x_left),
      .rsp_level_x_right   (rsp_level_x_right),
      .rsp_level_y_left    (rsp_level_y_left),
      .rsp_level_y_right   (rsp_level_y_right),
      .rsp_level_middle    (rsp_level_middle),
      .rsp_lateral_error   (rsp_lateral_error),
      .rsp_vertical_error  (rsp_vertical_error),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Every level report taken at a rising edge goes straight to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         levels_sb.check_result({rsp_level_middle, rsp_level_y_right, rsp_level_y_left,
                                 rsp_level_x_right, rsp_level_x_left,
                                 rsp_lateral_error, rsp_vertical_error});
   end

   // Receiver: random stall bursts, plus one long hold when the sequencer asks,
   // which keeps a finished update waiting in the block and stalls new requests.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall = 1'b1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = LONG_HOLD - 1;
         rsp_stall    = 1'b1;
      end else if (stall_burst > 0) begin
         stall_burst--;
         rsp_stall = 1'b1;
      end else if (receiver_idling && $urandom_range(0, 4) == 0) begin
         stall_burst = $urandom_range(1, 10) - 1;
         rsp_stall   = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // Offers one request and returns at the edge that accepts it. Valid stays high
   // into the next request unless a gap is drawn.
   task automatic send_request(input logic [2:0] f, input logic [4:0][7:0] rd);
      @(negedge clock);
      if (sender_idling && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_func     = f;
      req_readings = rd;
      do @(posedge clock); while (req_stall);
      levels_sb.note_request(f, rd);
      if (f < FUNC_FIRST_UNUSED) requests_sent++;
   endtask

   task automatic send_uniform(input logic [2:0] f, input logic [7:0] v);
      send_request(f, {5{v}});
   endtask

   // Registers are only touched while nothing is in flight: drain the reports,
   // then give a calibrate or preset time to finish its gain division.
   task automatic drain_block();
      @(negedge clock);
      req_valid = 1'b0;
      while (levels_sb.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [22:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_data  = data;
      levels_sb.configure(idx, data);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // One well-formed burst: a run of samples near a drifting level and an update,
   // or a bounds operation, or now and then an unused code as noise.
   task automatic random_sequence();
      logic [4:0][7:0] rd;
      logic [7:0] centre;
      int         run;
      int         pick;
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
         send_uniform(3'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED)), 8'($urandom));
      end else if (pick == 1) begin
         send_uniform(FUNC_CALIB, 8'($urandom));
      end else if (pick == 2) begin
         send_uniform(FUNC_CLEAR, 8'($urandom));
      end else if (pick == 3) begin
         send_uniform(FUNC_PRESET, 8'($urandom));
      end else begin
         // An occasional long run can overfill the sample counter.
         run    = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 270)
                                               : $urandom_range(0, 12);
         centre = 8'($urandom);
         for (int i = 0; i < run; i++) begin
            for (int c = 0; c < 5; c++) begin
               if ($urandom_range(0, 3) == 0) rd[c] = 8'($urandom);
               else rd[c] = (centre > 8'd239) ? centre - 8'($urandom_range(0, 15))
                                              : centre + 8'($urandom_range(0, 15));
            end
            send_request(FUNC_SAMPLE, rd);
         end
         send_uniform(FUNC_UPDATE, 8'($urandom));
      end
   endtask

   initial begin
      int target;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_register(CSR_PRESET_SELECT, 23'd1);
      write_register(CSR_MIDDLE_GAIN, 23'd0);

      // Directed part: an update before any sample and with zero levels (saturated
      // reciprocals), the first table, reading extremes, calibrate, clear and the
      // unused codes.
      send_uniform(FUNC_UPDATE, 8'h00);
      send_uniform(FUNC_PRESET, 8'h00);
      send_uniform(FUNC_SAMPLE, 8'h00);
      send_uniform(FUNC_SAMPLE, 8'hFF);
      send_uniform(FUNC_UPDATE, 8'h00);
      send_uniform(FUNC_SAMPLE, 8'h05);
      send_uniform(FUNC_UPDATE, 8'h00);          // average below the floor: level kept
      send_uniform(FUNC_CALIB, 8'h00);
      send_request(FUNC_SAMPLE, {8'd200, 8'd30, 8'd250, 8'd12, 8'd255});
      send_request(FUNC_SAMPLE, {8'd180, 8'd60, 8'd240, 8'd10, 8'd1});
      send_uniform(FUNC_UPDATE, 8'h00);
      send_uniform(FUNC_CALIB, 8'h00);
      send_request(FUNC_SAMPLE, {8'd90, 8'd255, 8'd0, 8'd128, 8'd77});
      send_uniform(FUNC_UPDATE, 8'h00);
      send_uniform(FUNC_CLEAR, 8'h00);
      send_uniform(FUNC_CALIB, 8'h00);          // empty ranges after clear
      send_uniform(FUNC_FIRST_UNUSED, 8'hAA);
      send_uniform(3'd6, 8'h55);
      send_uniform(FUNC_LAST_UNUSED, 8'hFF);
      send_uniform(FUNC_SAMPLE, 8'h80);
      send_uniform(FUNC_UPDATE, 8'h00);
      drain_block();

      // Random phases, each under its own register setting. The second phase holds
      // the receiver off for a long stretch; the last one runs with no idling.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_PRESET_SELECT, 23'd2);
               write_register(CSR_MIDDLE_GAIN, 23'd5242880);
            end
            1: begin
               write_register(CSR_PRESET_SELECT, 23'd0);
               write_register(CSR_MIDDLE_GAIN, 23'($urandom_range(0, 5242880)));
            end
            2: begin
               write_register(CSR_PRESET_SELECT, 23'd3);
               write_register(CSR_MIDDLE_GAIN, 23'd0);
            end
            3: begin
               write_register(CSR_PRESET_SELECT, 23'd1);
               write_register(CSR_MIDDLE_GAIN, 23'($urandom_range(4194304, 5242880)));
            end
            default: begin
               write_register(CSR_PRESET_SELECT, 23'($urandom_range(0, 3)));
               write_register(CSR_MIDDLE_GAIN, 23'($urandom_range(0, 5242880)));
            end
         endcase
         sender_idling   = (phase != 4) && (phase != 2);
         receiver_idling = (phase != 4) && (phase != 0);
         if (phase == 1) hold_request = 1'b1;
         target = requests_sent + 260;
         while (requests_sent < target) random_sequence();
         drain_block();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (levels_sb.errors == 0 && levels_sb.outstanding() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire
